>>> src/clcd_pkg.sv
// Shared types, constants and lookup functions for the character LCD interface.
package clcd_pkg;

  // Display geometry
  localparam int LINE_LENGTH = 20;
  localparam int LINE_COUNT  = 4;

  // Event counts per request
  localparam int EVT_W        = 6;
  localparam int PWR_EVENTS   = 36;
  localparam int BYTE_EVENTS  = 4;
  localparam int PWR_NIB_EVTS = 8;   // four single-nibble writes, two events each

  // First power-up event that belongs to the byte commands
  localparam logic [EVT_W-1:0] EVT_PWR_NIB = EVT_W'(PWR_NIB_EVTS);

  // Power-up nibbles
  localparam logic [3:0] PWR_NIB_A = 4'h3;
  localparam logic [3:0] PWR_NIB_B = 4'h2;

  localparam logic [7:0] SET_DDRAM = 8'h80;
  localparam logic [4:0] BASE_WAIT = 5'd1;

  typedef enum logic [1:0] {
    REQ_PWRUP  = 2'd0,
    REQ_CMD    = 2'd1,
    REQ_DATA   = 2'd2,
    REQ_CURSOR = 2'd3
  } req_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;
    logic             emit;
    logic [EVT_W-1:0] evt;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic last_evt;
    logic req_ok;
  } stat_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h08;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h1C;
      3'd5:    b = 8'h02;
      3'd6:    b = 8'h0C;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] row_offset(input logic [1:0] ln);
    logic [7:0] o;
    case (ln)
      2'd0:    o = 8'd0;
      2'd1:    o = 8'd64;
      2'd2:    o = 8'd20;
      default: o = 8'd84;
    endcase
    return o;
  endfunction

  // Extra settle time ahead of each power-up nibble
  function automatic logic [4:0] pwr_extra(input logic [1:0] idx);
    logic [4:0] w;
    case (idx)
      2'd0:    w = 5'd15;
      2'd1:    w = 5'd5;
      2'd2:    w = 5'd1;
      default: w = 5'd0;
    endcase
    return w;
  endfunction

endpackage

>>> src/char_lcd_nibble_interface.sv
// Top level of the 4-bit character LCD interface: controller plus datapath.
// Each input transaction is one request: power-up sequence (36 pin events),
// command byte (4 events), data byte (4 events) or cursor move (4 events, or
// none when the line or column is off screen). Every result transaction is one
// pin state (RS, E, D7..D4) plus the wait in ms to apply before it; out_last
// marks the final event of a request. The controller issues one event per
// cycle while the output register is free, and pauses while it stays full.
// The block has a single output register and one event counter. A new
// request is accepted once the previous one's last event is in the output
// register, even if it has not yet been taken downstream.
module char_lcd_nibble_interface (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_byte_value,
  input  logic [4:0] in_column,
  input  logic [2:0] in_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_reg_select,
  output logic       out_enable_pin,
  output logic [3:0] out_bus_nibble,
  output logic [4:0] out_wait_ms_before,
  output logic       out_last
);

  clcd_pkg::cmd_t  cmd;
  clcd_pkg::stat_t stat;

  clcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clcd_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_type        (in_req_type),
    .in_byte_value      (in_byte_value),
    .in_column          (in_column),
    .in_line            (in_line),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reg_select     (out_reg_select),
    .out_enable_pin     (out_enable_pin),
    .out_bus_nibble     (out_bus_nibble),
    .out_wait_ms_before (out_wait_ms_before),
    .out_last           (out_last)
  );

endmodule

>>> src/clcd_datapath.sv
// Request registers, pin event generation and output register.
module clcd_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             in_req_type,
  input  logic [7:0]             in_byte_value,
  input  logic [4:0]             in_column,
  input  logic [2:0]             in_line,
  input  clcd_pkg::cmd_t         cmd,
  output clcd_pkg::stat_t        stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_reg_select,
  output logic                   out_enable_pin,
  output logic [3:0]             out_bus_nibble,
  output logic [4:0]             out_wait_ms_before,
  output logic                   out_last
);

  logic       pwr_r;
  logic       rs_r;
  logic [7:0] byte_r;

  logic       out_valid_r;
  logic       rs_out_r;
  logic       e_out_r;
  logic [3:0] nib_out_r;
  logic [4:0] wait_out_r;
  logic       last_out_r;

  logic [7:0] cur_addr;
  logic       req_ok;
  logic [clcd_pkg::EVT_W-1:0] sub_evt;
  logic [7:0] ev_byte;
  logic       ev_half;
  logic [3:0] ev_nib;
  logic [4:0] ev_extra;
  logic       ev_e;
  logic [4:0] ev_wait;
  logic       ev_last;

  // Cursor address and range check from the live input
  assign cur_addr = clcd_pkg::row_offset(in_line[1:0]) + {3'd0, in_column}
                    + clcd_pkg::SET_DDRAM;
  always_comb begin
    req_ok = 1'b1;
    if (clcd_pkg::req_t'(in_req_type) == clcd_pkg::REQ_CURSOR) begin
      req_ok = (in_line < 3'(clcd_pkg::LINE_COUNT)) &&
               ({1'b0, in_column} < 6'(clcd_pkg::LINE_LENGTH));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pwr_r  <= (clcd_pkg::req_t'(in_req_type) == clcd_pkg::REQ_PWRUP);
      rs_r   <= (clcd_pkg::req_t'(in_req_type) == clcd_pkg::REQ_DATA);
      byte_r <= (clcd_pkg::req_t'(in_req_type) == clcd_pkg::REQ_CURSOR) ?
                cur_addr : in_byte_value;
    end
  end

  // Event decode: even events raise E, odd events drop it
  assign sub_evt = cmd.evt - clcd_pkg::EVT_PWR_NIB;

  always_comb begin
    ev_byte  = byte_r;
    ev_half  = cmd.evt[1];
    ev_extra = 5'd0;
    ev_nib   = ev_half ? ev_byte[3:0] : ev_byte[7:4];
    if (pwr_r) begin
      if (cmd.evt < clcd_pkg::EVT_PWR_NIB) begin
        ev_nib   = (cmd.evt[2:1] == 2'd3) ? clcd_pkg::PWR_NIB_B : clcd_pkg::PWR_NIB_A;
        ev_extra = clcd_pkg::pwr_extra(cmd.evt[2:1]);
      end else begin
        ev_byte = clcd_pkg::init_byte(sub_evt[4:2]);
        ev_half = sub_evt[1];
        ev_nib  = ev_half ? ev_byte[3:0] : ev_byte[7:4];
      end
    end
  end

  assign ev_e    = ~cmd.evt[0];
  assign ev_wait = ev_e ? (clcd_pkg::BASE_WAIT + ev_extra) : clcd_pkg::BASE_WAIT;
  assign ev_last = pwr_r ? (cmd.evt == clcd_pkg::EVT_W'(clcd_pkg::PWR_EVENTS - 1))
                         : (cmd.evt == clcd_pkg::EVT_W'(clcd_pkg::BYTE_EVENTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rs_out_r   <= rs_r;
      e_out_r    <= ev_e;
      nib_out_r  <= ev_nib;
      wait_out_r <= ev_wait;
      last_out_r <= ev_last;
    end
  end

  assign stat.out_free = ~out_valid_r | out_ready;
  assign stat.last_evt = ev_last;
  assign stat.req_ok   = req_ok;

  assign out_valid          = out_valid_r;
  assign out_reg_select     = rs_out_r;
  assign out_enable_pin     = e_out_r;
  assign out_bus_nibble     = nib_out_r;
  assign out_wait_ms_before = wait_out_r;
  assign out_last           = last_out_r;

endmodule

>>> src/clcd_ctrl.sv
// Controller state machine: accepts requests and steps the event counter.
module clcd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  clcd_pkg::stat_t stat,
  output clcd_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  logic [clcd_pkg::EVT_W-1:0] evt_r, evt_nxt;
  logic                       accept;
  logic                       emit;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign emit     = (state_r == ST_RUN) & stat.out_free;

  always_comb begin
    state_nxt = state_r;
    evt_nxt   = evt_r;
    case (state_r)
      ST_IDLE: begin
        evt_nxt = '0;
        if (accept && stat.req_ok) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit) begin
          if (stat.last_evt) begin
            state_nxt = ST_IDLE;
            evt_nxt   = '0;
          end else begin
            evt_nxt = evt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        evt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      evt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      evt_r   <= evt_nxt;
    end
  end

  assign cmd.load = accept;
  assign cmd.emit = emit;
  assign cmd.evt  = evt_r;

  a_evt_range: assert property (@(posedge clk) disable iff (!rst_n)
    evt_r < clcd_pkg::EVT_W'(clcd_pkg::PWR_EVENTS))
    else $error("event counter out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    emit && stat.last_evt |=> state_r == ST_IDLE && evt_r == '0)
    else $error("request did not end after last event");

  a_run_starts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |=> state_r == ST_IDLE || evt_r == '0)
    else $error("request started at nonzero event");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the 4-bit character LCD interface block.
module testbench;

  // Watchdog: cycles with no transaction on either channel before giving up.
  localparam int STALL_LIMIT   = 3000;
  // Long receiver hold-off used to fill the block and back up the request side.
  localparam int HOLD_CYCLES   = 300;
  // Quiet cycles after the last expected event, to catch stray extra events.
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_ITEMS  = 300;

  // Receiver stall patterns.
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_BURST_STALL
  } rx_mode_t;

  // One expected pin event, in the order the block must present it.
  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic [4:0] wait_ms;
    logic       last;
  } pin_event_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_req_type;
  logic [7:0] in_byte_value;
  logic [4:0] in_column;
  logic [2:0] in_line;
  logic       out_valid;
  logic       out_ready;
  logic       out_reg_select;
  logic       out_enable_pin;
  logic [3:0] out_bus_nibble;
  logic [4:0] out_wait_ms_before;
  logic       out_last;

  // Expected pin events, oldest first.
  pin_event_t pending_events[$];
  // Predicted RS, E, D7..D4 as last driven by the block.
  logic [5:0] pin_state;
  int         mismatch_count;
  int         quiet_cycles;
  // Set by a test to ask the receiver for a long hold-off; cleared by the receiver.
  bit         hold_req;

  // Controller power-up command bytes and display row base addresses.
  logic [7:0] pwrup_cmds [7] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h1C, 8'h02, 8'h0C};
  logic [7:0] row_base   [4] = '{8'd0, 8'd64, 8'd20, 8'd84};

  char_lcd_nibble_interface dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_byte_value     (in_byte_value),
    .in_column         (in_column),
    .in_line           (in_line),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reg_select    (out_reg_select),
    .out_enable_pin    (out_enable_pin),
    .out_bus_nibble    (out_bus_nibble),
    .out_wait_ms_before(out_wait_ms_before),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pin event prediction
  // ---------------------------------------------------------------------------

  // One nibble strobe: E rises with RS and the bus set up in the same event,
  // then E falls 1 ms later with RS and the bus left where they were.
  function automatic void predict_nibble(logic rs, logic [3:0] nib, logic [4:0] extra_ms);
    pin_event_t ev;
    pin_state = {rs, 1'b1, nib};
    ev = '{rs: pin_state[5], en: pin_state[4], nib: pin_state[3:0],
           wait_ms: 5'd1 + extra_ms, last: 1'b0};
    pending_events.push_back(ev);
    pin_state[4] = 1'b0;
    ev.en      = pin_state[4];
    ev.wait_ms = 5'd1;
    pending_events.push_back(ev);
  endfunction

  // Bytes go out high nibble first.
  function automatic void predict_byte(logic rs, logic [7:0] value);
    predict_nibble(rs, value[7:4], 5'd0);
    predict_nibble(rs, value[3:0], 5'd0);
  endfunction

  function automatic void predict_request(clcd_pkg::req_t req, logic [7:0] value,
                                          logic [4:0] col, logic [2:0] ln);
    int         first_new;
    logic [7:0] ddram_addr;
    first_new = pending_events.size();
    case (req)
      clcd_pkg::REQ_PWRUP: begin
        // Three wake-up nibbles with long settle times, then switch to 4-bit mode.
        predict_nibble(1'b0, 4'h3, 5'd15);
        predict_nibble(1'b0, 4'h3, 5'd5);
        predict_nibble(1'b0, 4'h3, 5'd1);
        predict_nibble(1'b0, 4'h2, 5'd0);
        foreach (pwrup_cmds[i]) predict_byte(1'b0, pwrup_cmds[i]);
      end
      clcd_pkg::REQ_CMD:  predict_byte(1'b0, value);
      clcd_pkg::REQ_DATA: predict_byte(1'b1, value);
      default: begin
        // Cursor move: the address byte when on screen; off screen nothing is sent and the pins stay as they were.
        if (ln < clcd_pkg::LINE_COUNT && col < clcd_pkg::LINE_LENGTH) begin
          ddram_addr = row_base[ln[1:0]] + 8'(col) + clcd_pkg::SET_DDRAM;
          predict_byte(1'b0, ddram_addr);
        end
      end
    endcase
    if (pending_events.size() > first_new)
      pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch(name, got, want);
  endtask

  // Requests are predicted first so an event can never race its own request.
  always @(posedge clk) begin : monitor
    pin_event_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        predict_request(clcd_pkg::req_t'(in_req_type), in_byte_value, in_column, in_line);
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch("unexpected pin event, nibble", out_bus_nibble, -1);
        end else begin
          want = pending_events.pop_front();
          check_field("reg_select", out_reg_select, want.rs);
          check_field("enable_pin", out_enable_pin, want.en);
          check_field("bus_nibble", out_bus_nibble, want.nib);
          check_field("wait_ms_before", out_wait_ms_before, want.wait_ms);
          check_field("last", out_last, want.last);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction at all.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** char_lcd_nibble_interface: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: changes its stall pattern segment by segment, and honors a long
  // hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_t mode;
    int       seg_left;
    int       held;
    mode     = RX_ALWAYS;
    seg_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        held = 0;
        while (held < HOLD_CYCLES) begin
          out_ready <= 1'b0;
          held++;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        mode     = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(10, 60);
      end
      seg_left--;
      case (mode)
        RX_ALWAYS:   out_ready <= 1'b1;
        RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_ready <= (seg_left % 4) != 0;
        default:     out_ready <= seg_left >= 12;  // closing stretch held low
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Presents one request and holds it until the block takes it. Valid stays
  // high afterwards until the next falling edge decides what comes next.
  task automatic send_request(clcd_pkg::req_t req, logic [7:0] value, logic [4:0] col,
                              logic [2:0] ln);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_byte_value <= value;
    in_column     <= col;
    in_line       <= ln;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid for a number of cycles; the idle payload is noise.
  task automatic idle_request(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_req_type   <= 2'($urandom);
      in_byte_value <= 8'($urandom);
      in_column     <= 5'($urandom);
      in_line       <= 3'($urandom);
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  function automatic logic [4:0] any_column();
    return 5'($urandom_range(0, clcd_pkg::LINE_LENGTH - 1));
  endfunction

  function automatic logic [2:0] any_line();
    return 3'($urandom_range(0, clcd_pkg::LINE_COUNT - 1));
  endfunction

  // Power-up sequence, first out of reset and again later with junk in the
  // fields it does not use.
  task automatic test_power_up();
    send_request(clcd_pkg::REQ_PWRUP, 8'h00, 5'd0, 3'd0);
    idle_request(3);
    send_request(clcd_pkg::REQ_PWRUP, 8'hFF, 5'd31, 3'd7);
  endtask

  // Command and data writes at byte extremes and alternating bit patterns.
  task automatic test_byte_writes();
    send_request(clcd_pkg::REQ_CMD, 8'h00, 5'd0, 3'd0);
    send_request(clcd_pkg::REQ_CMD, 8'hFF, 5'd31, 3'd7);
    send_request(clcd_pkg::REQ_CMD, 8'hA5, any_column(), any_line());
    idle_request(2);
    send_request(clcd_pkg::REQ_DATA, 8'h00, 5'd0, 3'd0);
    send_request(clcd_pkg::REQ_DATA, 8'hFF, 5'd31, 3'd7);
    send_request(clcd_pkg::REQ_DATA, 8'h5A, any_column(), any_line());
  endtask

  // Cursor moves: every row base, first and last column, and the off-screen
  // cases on line, column and both.
  task automatic test_cursor_moves();
    send_request(clcd_pkg::REQ_CURSOR, 8'h00, 5'd0, 3'd0);
    send_request(clcd_pkg::REQ_CURSOR, 8'hFF, 5'(clcd_pkg::LINE_LENGTH - 1), 3'd1);
    send_request(clcd_pkg::REQ_CURSOR, 8'h00, 5'd0, 3'd2);
    send_request(clcd_pkg::REQ_CURSOR, 8'h00, 5'(clcd_pkg::LINE_LENGTH - 1),
                 3'(clcd_pkg::LINE_COUNT - 1));
    send_request(clcd_pkg::REQ_CURSOR, 8'h00, 5'd0, 3'(clcd_pkg::LINE_COUNT));
    send_request(clcd_pkg::REQ_CURSOR, 8'h00, 5'(clcd_pkg::LINE_LENGTH), 3'd0);
    send_request(clcd_pkg::REQ_CURSOR, 8'hFF, 5'd31, 3'd7);
    // An off-screen move must not disturb the write that follows it.
    send_request(clcd_pkg::REQ_DATA, 8'h41, 5'd31, 3'd7);
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // output register fills and the block stops taking requests.
  task automatic test_output_hold();
    hold_req = 1'b1;
    send_request(clcd_pkg::REQ_PWRUP, 8'($urandom), 5'($urandom), 3'($urandom));
    repeat (10) begin
      send_request(clcd_pkg::req_t'($urandom_range(clcd_pkg::REQ_CMD, clcd_pkg::REQ_CURSOR)),
                   8'($urandom), any_column(), any_line());
    end
    wait (hold_req == 1'b0);
  endtask

  // Random traffic in bursts: mostly byte writes and on-screen cursor moves,
  // some power-up sequences and a share of arbitrary cursor fields.
  task automatic test_random_traffic();
    int             sent;
    int             burst;
    int             pick;
    clcd_pkg::req_t req;
    logic [4:0]     col;
    logic [2:0]     ln;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        col  = any_column();
        ln   = any_line();
        if (pick < 3)       req = clcd_pkg::REQ_PWRUP;
        else if (pick < 40) req = clcd_pkg::REQ_CMD;
        else if (pick < 75) req = clcd_pkg::REQ_DATA;
        else begin
          req = clcd_pkg::REQ_CURSOR;
          if (pick >= 92) begin
            col = 5'($urandom);
            ln  = 3'($urandom);
          end
        end
        send_request(req, 8'($urandom), col, ln);
        sent++;
      end
      // A quarter of bursts run straight into the next one.
      if ($urandom_range(0, 3) != 0) idle_request($urandom_range(1, 15));
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = clcd_pkg::REQ_PWRUP;
    in_byte_value = 8'h00;
    in_column     = 5'd0;
    in_line       = 3'd0;
    hold_req      = 1'b0;
    mismatch_count = 0;
    quiet_cycles  = 0;
    pin_state     = 6'd0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_power_up();
    test_byte_writes();
    test_cursor_moves();
    test_output_hold();
    test_random_traffic();
    idle_request(1);

    // Drain, then give the block time to show any extra events.
    wait (pending_events.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_events.size() != 0)
      report_mismatch("events never produced", 0, pending_events.size());

    if (mismatch_count == 0)
      $display("** char_lcd_nibble_interface: PASSED **");
    else
      $display("** char_lcd_nibble_interface: FAILED **");
    $finish;
  end

endmodule

>>> files.f
src/clcd_pkg.sv
src/clcd_datapath.sv
src/clcd_ctrl.sv
src/char_lcd_nibble_interface.sv
dv/testbench.sv
